// ===== hdl/tcp_header_option_parser_top_assert.svh =====
// assertion macros for the tcp header and option parser
`ifndef TCP_HEADER_OPTION_PARSER_TOP_ASSERT_SVH
`define TCP_HEADER_OPTION_PARSER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define THOP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define THOP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define THOP_ASSERT(lbl, prop, msg)

`define THOP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hdl/thop_pkg.sv =====
// shared types and constants for the tcp header and option parser
package thop_pkg;

  typedef enum logic [1:0] {
    PH_KIND,
    PH_LEN,
    PH_BODY,
    PH_STOP
  } opt_phase_t;

  typedef enum logic [1:0] {
    VERDICT_OK,
    VERDICT_SHORT,
    VERDICT_TRUNC,
    VERDICT_OPT_LONG
  } verdict_t;

  typedef struct packed {
    opt_phase_t  phase;
    logic [7:0]  kind;
    logic [7:0]  body_left;
    logic        ws_valid;
    logic [7:0]  ws_value;
    logic        err;
  } walk_t;

  localparam logic [7:0]  KIND_EOL     = 8'd0;
  localparam logic [7:0]  KIND_NOP     = 8'd1;
  localparam logic [7:0]  KIND_WSCALE  = 8'd3;
  localparam logic [7:0]  WSCALE_LEN   = 8'd3;
  localparam logic [7:0]  MIN_OPT_LEN  = 8'd2;

  localparam logic [15:0] POS_SRC_HI    = 16'd0;
  localparam logic [15:0] POS_SRC_LO    = 16'd1;
  localparam logic [15:0] POS_DST_HI    = 16'd2;
  localparam logic [15:0] POS_DST_LO    = 16'd3;
  localparam logic [15:0] POS_OFFSET    = 16'd12;
  localparam logic [15:0] POS_FLAGS     = 16'd13;
  localparam logic [15:0] POS_OPT_START = 16'd20;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  localparam logic [15:0] MIN_SEG_LEN      = 16'd20;
  localparam logic [5:0]  BASE_HDR_LEN     = 6'd20;
  localparam logic [5:0]  MAX_OPTION_BYTES = 6'd40;

endpackage

// ===== hdl/thop_opt_walk.sv =====
// kind/length/body step of the tcp option walk, one option byte per call
module thop_opt_walk
  import thop_pkg::*;
(
  input  walk_t      cur,
  input  logic [7:0] opt_byte,
  input  logic [5:0] area_left,
  output walk_t      nxt
);

  logic [8:0] len_limit;

  // the kind byte came one earlier, so the area then held one more byte
  assign len_limit = {3'b000, area_left} + 9'd1;

  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      PH_KIND: begin
        if (opt_byte == KIND_EOL) begin
          nxt.phase = PH_STOP;
        end else if (opt_byte == KIND_NOP) begin
          nxt.phase = PH_KIND;
        end else if ({2'b00, area_left} < MIN_OPT_LEN) begin
          nxt.phase = PH_STOP;
        end else begin
          nxt.kind  = opt_byte;
          nxt.phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (({1'b0, opt_byte} > len_limit) || (opt_byte < MIN_OPT_LEN)) begin
          nxt.err   = 1'b1;
          nxt.phase = PH_STOP;
        end else begin
          // keep the kind only for the first window scale of proper length
          if (!(cur.kind == KIND_WSCALE && opt_byte == WSCALE_LEN && !cur.ws_valid)) begin
            nxt.kind = KIND_EOL;
          end
          nxt.body_left = opt_byte - MIN_OPT_LEN;
          nxt.phase     = (opt_byte == MIN_OPT_LEN) ? PH_KIND : PH_BODY;
        end
      end
      PH_BODY: begin
        if (cur.kind == KIND_WSCALE) begin
          nxt.ws_value = opt_byte;
          nxt.ws_valid = 1'b1;
          nxt.kind     = KIND_EOL;
        end
        nxt.body_left = cur.body_left - 8'd1;
        if (cur.body_left == 8'd1) begin
          nxt.phase = PH_KIND;
        end
      end
      PH_STOP: begin
        nxt = cur;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ===== hdl/tcp_header_option_parser_top.sv =====
// The result is registered: it appears in the output register in the cycle after the last beat is taken.
// Throughput: one byte beat per cycle; header state and the option walk update in that cycle.
// in_tready drops only for a last beat while an earlier result is still held at the output.
// Reset (rst_n low at a clock edge) returns to the start of a segment with no result pending.
// After each last beat the parser state clears itself for the next segment.
`include "tcp_header_option_parser_top_assert.svh"

module tcp_header_option_parser_top
  import thop_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] verdict, [17:2] source_port, [33:18] dest_port, [39:34] header_length,
  // [55:40] payload_length, [56] syn_seen, [57] wscale_present,
  // [65:58] wscale_shift, [66] option_error, [71:67] zero
  output logic [71:0] out_tdata
);

  localparam walk_t WALK_RESET = '{phase: PH_KIND, kind: KIND_EOL, body_left: 8'd0,
                                   ws_valid: 1'b0, ws_value: 8'd0, err: 1'b0};

  logic        in_fire;
  logic [7:0]  b;

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] src_r, src_nxt;
  logic [15:0] dst_r, dst_nxt;
  logic [3:0]  offset_r, offset_nxt;
  logic        syn_r, syn_nxt;
  logic [5:0]  opt_left_r, opt_left_nxt;
  walk_t       walk_r, walk_nxt, walk_step;

  logic [5:0]  hl_byte;
  logic [5:0]  hlen;
  logic [15:0] seg_len;
  verdict_t    verdict;

  logic        out_valid_r, out_valid_nxt;
  verdict_t    o_verdict_r, o_verdict_nxt;
  logic [15:0] o_src_r, o_src_nxt;
  logic [15:0] o_dst_r, o_dst_nxt;
  logic [5:0]  o_hlen_r, o_hlen_nxt;
  logic [15:0] o_pay_r, o_pay_nxt;
  logic        o_syn_r, o_syn_nxt;
  logic        o_wsp_r, o_wsp_nxt;
  logic [7:0]  o_wss_r, o_wss_nxt;
  logic        o_err_r, o_err_nxt;

  // non-last beats never produce a result, so they pass even while output is held
  assign in_tready = !out_valid_r || out_tready || !in_tlast;
  assign in_fire   = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign hl_byte   = {b[7:4], 2'b00};

  thop_opt_walk u_walk (
    .cur       (walk_r),
    .opt_byte  (b),
    .area_left (opt_left_r),
    .nxt       (walk_step)
  );

  // header capture and option walk for the accepted beat
  always_comb begin
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    offset_nxt   = offset_r;
    syn_nxt      = syn_r;
    opt_left_nxt = opt_left_r;
    walk_nxt     = walk_r;
    priority if (pos_r == POS_SRC_HI) begin
      src_nxt[15:8] = b;
    end else if (pos_r == POS_SRC_LO) begin
      src_nxt[7:0] = b;
    end else if (pos_r == POS_DST_HI) begin
      dst_nxt[15:8] = b;
    end else if (pos_r == POS_DST_LO) begin
      dst_nxt[7:0] = b;
    end else if (pos_r == POS_OFFSET) begin
      offset_nxt   = b[7:4];
      opt_left_nxt = (hl_byte >= BASE_HDR_LEN) ? (hl_byte - BASE_HDR_LEN) : 6'd0;
    end else if (pos_r == POS_FLAGS) begin
      syn_nxt = b[1];
    end else if (pos_r >= POS_OPT_START && opt_left_r != 6'd0) begin
      walk_nxt     = walk_step;
      opt_left_nxt = opt_left_r - 6'd1;
    end else begin
      walk_nxt = walk_r;
    end
    pos_nxt = (pos_r == POS_MAX) ? POS_MAX : pos_r + 16'd1;
  end

  // verdict from the state as it stands after this beat
  assign hlen    = {offset_nxt, 2'b00};
  assign seg_len = (pos_r == POS_MAX) ? POS_MAX : pos_r + 16'd1;

  always_comb begin
    priority if (seg_len < MIN_SEG_LEN) begin
      verdict = VERDICT_SHORT;
    end else if (seg_len < {10'd0, hlen}) begin
      verdict = VERDICT_TRUNC;
    end else if (hlen < BASE_HDR_LEN || (hlen - BASE_HDR_LEN) > MAX_OPTION_BYTES) begin
      // an offset under five wraps to a huge option area
      verdict = VERDICT_OPT_LONG;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_comb begin
    o_verdict_nxt = o_verdict_r;
    o_src_nxt     = o_src_r;
    o_dst_nxt     = o_dst_r;
    o_hlen_nxt    = o_hlen_r;
    o_pay_nxt     = o_pay_r;
    o_syn_nxt     = o_syn_r;
    o_wsp_nxt     = o_wsp_r;
    o_wss_nxt     = o_wss_r;
    o_err_nxt     = o_err_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    if (in_fire && in_tlast) begin
      out_valid_nxt = 1'b1;
      o_verdict_nxt = verdict;
      o_hlen_nxt    = hlen;
      if (verdict == VERDICT_OK) begin
        o_src_nxt = src_nxt;
        o_dst_nxt = dst_nxt;
        o_pay_nxt = seg_len - {10'd0, hlen};
        o_syn_nxt = syn_nxt;
        o_wsp_nxt = walk_nxt.ws_valid;
        o_wss_nxt = walk_nxt.ws_valid ? walk_nxt.ws_value : 8'd0;
        o_err_nxt = walk_nxt.err;
      end else begin
        o_src_nxt = 16'd0;
        o_dst_nxt = 16'd0;
        o_pay_nxt = 16'd0;
        o_syn_nxt = 1'b0;
        o_wsp_nxt = 1'b0;
        o_wss_nxt = 8'd0;
        o_err_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 16'd0;
      offset_r    <= 4'd0;
      syn_r       <= 1'b0;
      opt_left_r  <= 6'd0;
      walk_r      <= WALK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        if (in_tlast) begin
          pos_r      <= 16'd0;
          offset_r   <= 4'd0;
          syn_r      <= 1'b0;
          opt_left_r <= 6'd0;
          walk_r     <= WALK_RESET;
        end else begin
          pos_r      <= pos_nxt;
          offset_r   <= offset_nxt;
          syn_r      <= syn_nxt;
          opt_left_r <= opt_left_nxt;
          walk_r     <= walk_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      src_r <= src_nxt;
      dst_r <= dst_nxt;
    end
    o_verdict_r <= o_verdict_nxt;
    o_src_r     <= o_src_nxt;
    o_dst_r     <= o_dst_nxt;
    o_hlen_r    <= o_hlen_nxt;
    o_pay_r     <= o_pay_nxt;
    o_syn_r     <= o_syn_nxt;
    o_wsp_r     <= o_wsp_nxt;
    o_wss_r     <= o_wss_nxt;
    o_err_r     <= o_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, o_err_r, o_wss_r, o_wsp_r, o_syn_r, o_pay_r, o_hlen_r,
                       o_dst_r, o_src_r, o_verdict_r};

  `THOP_ASSERT(a_last_gives_result, in_fire && in_tlast |=> out_valid_r, "last beat lost its result")
  `THOP_ASSERT(a_last_clears_pos, in_fire && in_tlast |=> pos_r == 16'd0, "position not cleared after last beat")
  `THOP_ASSERT(a_drop_zeroes, out_valid_r && o_verdict_r != VERDICT_OK |-> o_pay_r == 16'd0 && !o_err_r && !o_wsp_r, "dropped segment carries fields")
  `THOP_ASSERT(a_stall_only_last, !in_tready |-> out_valid_r && !out_tready && in_tlast, "input stalled without cause")
  `THOP_ASSERT(a_wscale_gated, out_valid_r && !o_wsp_r |-> o_wss_r == 8'd0, "window scale shift without option")

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the tcp header and option parser: byte stream in, verdict beats out
module testbench;
  import thop_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  // option kinds used to build well-formed option lists
  localparam logic [7:0] KIND_MSS     = 8'd2;
  localparam logic [7:0] KIND_SACK_OK = 8'd4;
  localparam logic [7:0] KIND_TSTAMP  = 8'd8;

  // out_tdata layout, highest field first
  typedef struct packed {
    logic [4:0]  pad;
    logic        opt_err;
    logic [7:0]  ws_shift;
    logic        ws_present;
    logic        syn;
    logic [15:0] payload;
    logic [5:0]  hdr_len;
    logic [15:0] dst;
    logic [15:0] src;
    verdict_t    verdict;
  } seg_result_t;

  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] src;
    logic [15:0] dst;
    logic [3:0]  offs;
    logic        syn;
    opt_phase_t  phase;
    logic [5:0]  opt_left;
    logic [7:0]  body_left;
    logic [7:0]  kind;
    logic        ws_valid;
    logic [7:0]  ws_value;
    logic        err;
  } parse_state_t;

  typedef struct packed {
    logic        typed;
    seg_result_t want;
  } seg_note_t;

  typedef struct packed {
    logic [15:0]      src;
    logic [15:0]      dst;
    logic [3:0]       offs;
    logic [7:0]       flags;
    logic [0:15][7:0] opts;
    logic [16:0]      seg_len;
    logic             typed;
    seg_result_t      want;
  } seg_case_t;

  localparam seg_result_t NO_REPORT = '0;
  localparam seg_note_t   NO_NOTE   = '0;
  localparam parse_state_t PARSER_IDLE = '{pos: '0, src: '0, dst: '0, offs: '0, syn: 1'b0,
                                           phase: PH_KIND, opt_left: '0, body_left: '0,
                                           kind: '0, ws_valid: 1'b0, ws_value: '0,
                                           err: 1'b0};

  localparam int NUM_DIRECTED = 19;
  // want: pad, opt_err, ws_shift, ws_present, syn, payload, hdr_len, dst, src, verdict
  localparam seg_case_t DIRECTED_SEGS [NUM_DIRECTED] = '{
    // one-byte segment, offset never seen
    '{16'hABCD, 16'h1234, 4'd5, 8'h02, {16{KIND_NOP}}, 17'd1, 1'b1,
      '{5'd0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 6'd0, 16'h0, 16'h0, VERDICT_SHORT}},
    '{16'h0001, 16'h0002, 4'd15, 8'h12, {16{KIND_NOP}}, 17'd19, 1'b1,
      '{5'd0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 6'd60, 16'h0, 16'h0, VERDICT_SHORT}},
    // offsets under 5 wrap into a huge option area
    '{16'h1111, 16'h2222, 4'd4, 8'h02, {16{KIND_NOP}}, 17'd20, 1'b1,
      '{5'd0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 6'd16, 16'h0, 16'h0, VERDICT_OPT_LONG}},
    '{16'h3333, 16'h4444, 4'd0, 8'h02, {16{KIND_NOP}}, 17'd20, 1'b1,
      '{5'd0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 6'd0, 16'h0, 16'h0, VERDICT_OPT_LONG}},
    '{16'h5555, 16'h6666, 4'd15, 8'hFF, {16{KIND_NOP}}, 17'd59, 1'b1,
      '{5'd0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 6'd60, 16'h0, 16'h0, VERDICT_TRUNC}},
    '{16'hFFFF, 16'h0000, 4'd5, 8'hFF, {16{KIND_NOP}}, 17'd20, 1'b1,
      '{5'd0, 1'b0, 8'd0, 1'b0, 1'b1, 16'd0, 6'd20, 16'h0000, 16'hFFFF, VERDICT_OK}},
    '{16'h0000, 16'hFFFF, 4'd5, 8'hFD, {16{KIND_NOP}}, 17'd24, 1'b1,
      '{5'd0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd4, 6'd20, 16'hFFFF, 16'h0000, VERDICT_OK}},
    '{16'h1234, 16'h0050, 4'd6, 8'h02,
      {KIND_WSCALE, WSCALE_LEN, 8'd14, KIND_EOL, {12{KIND_NOP}}}, 17'd24, 1'b1,
      '{5'd0, 1'b0, 8'd14, 1'b1, 1'b1, 16'd0, 6'd24, 16'h0050, 16'h1234, VERDICT_OK}},
    // full option area, window scale followed by NOP padding
    '{16'h0400, 16'h01BB, 4'd15, 8'h02,
      {{13{KIND_NOP}}, KIND_WSCALE, WSCALE_LEN, 8'hFF}, 17'd80, 1'b0, NO_REPORT},
    // length under two
    '{16'h0101, 16'h0202, 4'd6, 8'h10, {8'd5, 8'd1, {14{KIND_NOP}}}, 17'd30, 1'b0, NO_REPORT},
    // length runs past the area
    '{16'h0303, 16'h0404, 4'd6, 8'h10, {KIND_MSS, 8'd10, {14{KIND_NOP}}}, 17'd24, 1'b0,
      NO_REPORT},
    // kind byte on the last area byte
    '{16'h0505, 16'h0606, 4'd6, 8'h10, {{3{KIND_NOP}}, KIND_TSTAMP, {12{KIND_NOP}}}, 17'd24,
      1'b0, NO_REPORT},
    // repeated window scale keeps the first
    '{16'h0707, 16'h0808, 4'd7, 8'h02,
      {KIND_WSCALE, WSCALE_LEN, 8'd7, KIND_WSCALE, WSCALE_LEN, 8'd9, KIND_EOL, KIND_EOL,
       {8{KIND_NOP}}}, 17'd28, 1'b0, NO_REPORT},
    // window scale of length 4 ignored, later valid one kept
    '{16'h0909, 16'h0A0A, 4'd8, 8'h02,
      {KIND_WSCALE, 8'd4, 8'd5, 8'd6, KIND_WSCALE, WSCALE_LEN, 8'd9, KIND_NOP,
       {8{KIND_NOP}}}, 17'd40, 1'b0, NO_REPORT},
    // end of list hides a later window scale
    '{16'h0B0B, 16'h0C0C, 4'd7, 8'h02,
      {KIND_EOL, KIND_WSCALE, WSCALE_LEN, 8'd7, {12{KIND_NOP}}}, 17'd28, 1'b0, NO_REPORT},
    '{16'h0D0D, 16'h0E0E, 4'd7, 8'h02,
      {KIND_SACK_OK, 8'd2, KIND_MSS, 8'd4, 8'd5, 8'd180, KIND_WSCALE, WSCALE_LEN,
       {8{KIND_NOP}}}, 17'd28, 1'b0, NO_REPORT},
    // option spanning the whole area, then one byte too long
    '{16'h0F0F, 16'h1010, 4'd15, 8'h00, {KIND_MSS, 8'd40, {14{KIND_NOP}}}, 17'd60, 1'b0,
      NO_REPORT},
    '{16'h1111, 16'h1212, 4'd15, 8'h00, {KIND_MSS, 8'd41, {14{KIND_NOP}}}, 17'd61, 1'b0,
      NO_REPORT},
    // long payload after a bare header
    '{16'hC000, 16'h0016, 4'd5, 8'h02, {16{KIND_NOP}}, 17'd100, 1'b0, NO_REPORT}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  // [1:0] verdict, [17:2] source_port, [33:18] dest_port, [39:34] header_length,
  // [55:40] payload_length, [56] syn_seen, [57] wscale_present,
  // [65:58] wscale_shift, [66] option_error, [71:67] zero
  logic [71:0] out_tdata;

  parse_state_t parser = PARSER_IDLE;
  seg_result_t  segment_reports_q [$];
  seg_note_t    segment_notes_q [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           sink_hold = 0;
  logic         sink_calm = 1'b0;

  tcp_header_option_parser_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // advances the header capture and option walk by one byte; returns 1 on a report
  function automatic logic track_byte(input logic [7:0] b, input logic last,
                                      output seg_result_t rep);
    logic [15:0] at;
    int          seg_len;
    int          hlen;
    int          opt_len;
    verdict_t    v;
    at  = parser.pos;
    rep = NO_REPORT;
    if (at == POS_SRC_HI) parser.src[15:8] = b;
    else if (at == POS_SRC_LO) parser.src[7:0] = b;
    else if (at == POS_DST_HI) parser.dst[15:8] = b;
    else if (at == POS_DST_LO) parser.dst[7:0] = b;
    else if (at == POS_OFFSET) begin
      parser.offs = b[7:4];
      hlen = int'(parser.offs) * 4;
      parser.opt_left = (hlen >= 20) ? 6'(hlen - 20) : 6'd0;
    end else if (at == POS_FLAGS) begin
      parser.syn = b[1];
    end else if (at >= POS_OPT_START && parser.opt_left != 0) begin
      case (parser.phase)
        PH_KIND: begin
          if (b == KIND_EOL) begin
            parser.phase = PH_STOP;
          end else if (b != KIND_NOP) begin
            if (parser.opt_left < 2) begin
              parser.phase = PH_STOP;
            end else begin
              parser.kind  = b;
              parser.phase = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          // the kind byte sat one position earlier, so its area was one byte larger
          if (int'(b) > int'(parser.opt_left) + 1 || b < MIN_OPT_LEN) begin
            parser.err   = 1'b1;
            parser.phase = PH_STOP;
          end else begin
            if (!(parser.kind == KIND_WSCALE && b == WSCALE_LEN && !parser.ws_valid))
              parser.kind = 8'd0;
            parser.body_left = b - MIN_OPT_LEN;
            parser.phase = (parser.body_left == 0) ? PH_KIND : PH_BODY;
          end
        end
        PH_BODY: begin
          if (parser.kind == KIND_WSCALE) begin
            parser.ws_value = b;
            parser.ws_valid = 1'b1;
            parser.kind     = 8'd0;
          end
          parser.body_left = parser.body_left - 8'd1;
          if (parser.body_left == 0) parser.phase = PH_KIND;
        end
        default: ;
      endcase
      parser.opt_left = parser.opt_left - 6'd1;
    end
    if (parser.pos != POS_MAX) parser.pos = parser.pos + 16'd1;
    if (!last) return 1'b0;

    seg_len = int'(at) + 1;
    if (seg_len > 65535) seg_len = 65535;
    hlen    = int'(parser.offs) * 4;
    opt_len = (hlen - 20) & 255;
    if (seg_len < int'(MIN_SEG_LEN)) v = VERDICT_SHORT;
    else if (seg_len < hlen) v = VERDICT_TRUNC;
    else if (opt_len > int'(MAX_OPTION_BYTES)) v = VERDICT_OPT_LONG;
    else v = VERDICT_OK;
    rep.verdict = v;
    rep.hdr_len = hlen[5:0];
    if (v == VERDICT_OK) begin
      rep.src        = parser.src;
      rep.dst        = parser.dst;
      rep.payload    = 16'(seg_len - hlen);
      rep.syn        = parser.syn;
      rep.ws_present = parser.ws_valid;
      rep.ws_shift   = parser.ws_valid ? parser.ws_value : 8'd0;
      rep.opt_err    = parser.err;
    end
    parser = PARSER_IDLE;
    return 1'b1;
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // predict on every accepted byte beat
  always @(posedge clk) begin : byte_monitor
    seg_result_t rep;
    seg_note_t   note;
    if (rst_n && in_tvalid && in_tready) begin
      if (track_byte(in_tdata, in_tlast, rep)) begin
        note = segment_notes_q.pop_front();
        if (note.typed) rep = note.want;
        segment_reports_q.push_back(rep);
      end
    end
  end

  always @(posedge clk) begin : report_checker
    seg_result_t got;
    seg_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = seg_result_t'(out_tdata);
      if (segment_reports_q.size() == 0) begin
        $display("%0t: unexpected report expected none got %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = segment_reports_q.pop_front();
        check_field("verdict", want.verdict, got.verdict);
        check_field("source_port", want.src, got.src);
        check_field("dest_port", want.dst, got.dst);
        check_field("header_length", want.hdr_len, got.hdr_len);
        check_field("payload_length", want.payload, got.payload);
        check_field("syn_seen", want.syn, got.syn);
        check_field("wscale_present", want.ws_present, got.ws_present);
        check_field("wscale_shift", want.ws_shift, got.ws_shift);
        check_field("option_error", want.opt_err, got.opt_err);
        check_field("pad", want.pad, got.pad);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // report sink: random stalls, calm stretches, and one long hold when asked
  initial begin : report_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_segment(input logic [15:0] src, input logic [15:0] dst,
                              input logic [3:0] offs, input logic [7:0] flags,
                              input logic [7:0] opts [$], input int seg_len,
                              input logic calm, input seg_note_t note);
    logic [7:0] b;
    int         gap;
    segment_notes_q.push_back(note);
    for (int i = 0; i < seg_len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == POS_SRC_HI) b = src[15:8];
      else if (i == POS_SRC_LO) b = src[7:0];
      else if (i == POS_DST_HI) b = dst[15:8];
      else if (i == POS_DST_LO) b = dst[7:0];
      else if (i == POS_OFFSET) b[7:4] = offs;
      else if (i == POS_FLAGS) b = flags;
      else if (i >= POS_OPT_START && i < 4 * int'(offs))
        b = (i - 20 < opts.size()) ? opts[i - 20] : KIND_NOP;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= b;
      in_tlast  <= (i == seg_len - 1);
      do @(posedge clk); while (!in_tready);
    end
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (segment_reports_q.size() != 0) @(posedge clk);
  endtask

  initial begin : segment_source
    logic [7:0] opts [$];
    logic [3:0] offs;
    logic       calm;
    int         rand_bytes;
    int         seg_count;
    int         calm_segs;
    int         shape;
    int         hlen;
    int         area;
    int         room;
    int         pick;
    int         need;
    int         len;
    int         pay;
    int         seg_len;
    rand_bytes = 0;
    seg_count  = 0;
    calm_segs  = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'd0;
    in_tlast   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      opts.delete();
      for (int k = 0; k < 16; k++) opts.push_back(DIRECTED_SEGS[r].opts[k]);
      send_segment(DIRECTED_SEGS[r].src, DIRECTED_SEGS[r].dst, DIRECTED_SEGS[r].offs,
                   DIRECTED_SEGS[r].flags, opts, int'(DIRECTED_SEGS[r].seg_len),
                   (DIRECTED_SEGS[r].seg_len > 2000) || $urandom_range(0, 1),
                   '{DIRECTED_SEGS[r].typed, DIRECTED_SEGS[r].want});
    end

    // mostly well-formed option lists, plus noise, short and truncated segments
    while (rand_bytes < 650 || seg_count < 11) begin
      shape = $urandom_range(0, 9);
      offs  = (shape < 7) ? 4'($urandom_range(5, 15)) : 4'($urandom_range(0, 15));
      if (shape == 9 && offs < 6) offs = 4'($urandom_range(6, 15));
      hlen = 4 * int'(offs);
      area = (hlen > 20) ? hlen - 20 : 0;
      opts.delete();
      while (opts.size() < area) begin
        room = area - opts.size();
        if (shape >= 7) begin
          opts.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 4)));
        end else begin
          pick = $urandom_range(0, 7);
          case (pick)
            1: need = 3;
            2: need = 4;
            3: need = 2;
            4: need = 10;
            5: need = 2;
            6: need = 4;
            default: need = 1;
          endcase
          if (need > room) pick = 0;
          case (pick)
            1: begin
              opts.push_back(KIND_WSCALE);
              opts.push_back(WSCALE_LEN);
              opts.push_back(8'($urandom_range(0, 255)));
            end
            2: begin
              opts.push_back(KIND_MSS);
              opts.push_back(8'd4);
              repeat (2) opts.push_back(8'($urandom_range(0, 255)));
            end
            3: begin
              opts.push_back(KIND_SACK_OK);
              opts.push_back(8'd2);
            end
            4: begin
              opts.push_back(KIND_TSTAMP);
              opts.push_back(8'd10);
              repeat (8) opts.push_back(8'($urandom_range(0, 255)));
            end
            5: begin
              len = $urandom_range(2, (room < 12) ? room : 12);
              opts.push_back(8'($urandom_range(2, 255)));
              opts.push_back(8'(len));
              repeat (len - 2) opts.push_back(8'($urandom_range(0, 255)));
            end
            6: begin
              opts.push_back(KIND_WSCALE);
              opts.push_back(8'd4);
              repeat (2) opts.push_back(8'($urandom_range(0, 255)));
            end
            7: opts.push_back(KIND_EOL);
            default: opts.push_back(KIND_NOP);
          endcase
        end
      end
      // occasionally break one byte of a well-formed list
      if (shape < 7 && area > 0 && $urandom_range(0, 7) == 0)
        opts[$urandom_range(0, area - 1)] = 8'($urandom_range(0, 3));
      pay = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 24);
      case (shape)
        7: seg_len = ((hlen > 20) ? hlen : 20) + pay;
        8: seg_len = $urandom_range(1, 19);
        9: seg_len = $urandom_range(20, hlen - 1);
        default: seg_len = hlen + pay;
      endcase
      calm = (calm_segs > 0) || ($urandom_range(0, 3) == 0);
      if (calm_segs > 0) calm_segs--;
      send_segment(16'($urandom), 16'($urandom), offs, 8'($urandom), opts, seg_len, calm,
                   NO_NOTE);
      rand_bytes += seg_len;
      seg_count++;
      // long sink hold while bytes keep flowing back to back
      if (seg_count == 5) begin
        sink_hold = 800;
        calm_segs = 8;
      end
      if (seg_count == 10) wait_for_results();
    end

    wait_for_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
